FILE: src/polyline_arc_coordinate_assert.svh
// Assertion macros for the polyline arc coordinate block.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef POLYLINE_ARC_COORDINATE_ASSERT_SVH
`define POLYLINE_ARC_COORDINATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition that holds at every clock edge out of reset.
`define PAC_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pac assertion failed: invariant");
// Condition that implies another in the same cycle.
`define PAC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pac assertion failed: implication");
`else
`define PAC_ASSERT_ALWAYS(lbl, cond)
`define PAC_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

FILE: src/pac_pkg.sv
// Shared types and constants of the polyline arc coordinate block.
// No dependencies; used by the interfaces and the top level.
package pac_pkg;

    localparam int OP_W      = 2;
    localparam int CRD_W     = 24;
    localparam int STAT_W    = 3;
    localparam int ARC_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int SNAP_W    = 16;
    localparam int TOL_W     = 8;

    // internal datapath widths
    localparam int DIF_W  = CRD_W + 1;     // vertex difference
    localparam int LEN_W  = CRD_W + 2;     // segment length
    localparam int P_W    = LEN_W + 1;     // projection after range check
    localparam int Q_W    = P_W + 1;       // projected coordinate
    localparam int E_W    = Q_W + 1;       // error vector component
    localparam int MUL_W  = E_W;           // multiplier operand
    localparam int PROD_W = 2 * MUL_W;     // multiplier product
    localparam int SQ_W   = PROD_W;        // square root radicand (even)
    localparam int DIV_W  = PROD_W;        // dividend / quotient
    localparam int DIVC_W = $clog2(DIV_W);
    localparam int DIST_W = SQ_W / 2;      // distance

    // operation codes
    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_STORED      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND       = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ON_PATH = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 2'd1;

    localparam logic [SNAP_W-1:0] SNAP_RESET = 16'd2048;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 8'd0;

endpackage

FILE: src/pac_if.sv
// Valid/ready channel interfaces: vertex/query requests, results, register writes.
// Depends on pac_pkg.
interface pac_in_if import pac_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [CRD_W-1:0] x_coord;
    logic signed [CRD_W-1:0] y_coord;
    modport source (output valid, operation, x_coord, y_coord, input ready);
    modport sink   (input valid, operation, x_coord, y_coord, output ready);
endinterface

interface pac_out_if import pac_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ARC_W-1:0]  arc_coord;
    modport source (output valid, status, arc_coord, input ready);
    modport sink   (input valid, status, arc_coord, output ready);
endinterface

interface pac_cfg_if import pac_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/polyline_arc_coordinate.sv
// Polyline arc coordinate: vertex store, projection sequencer, shared units.
// Depends on pac_pkg, pac_if and polyline_arc_coordinate_assert.svh.
//
//  channel  | dir | payload                         | accepted when
//  ---------+-----+---------------------------------+------------------
//  in_req   | in  | operation, x_coord, y_coord     | valid && ready
//  out_rsp  | out | status, arc_coord               | valid && ready
//  cfg      | in  | index, data                     | valid && ready
//
// A vertex write goes through the done state to a result. A query over n
// vertices works through each segment in turn: a 29-step square root for
// the length, three 58-step divisions on one shared restoring divider and,
// in the snap pass, one more square root. Vertices sit in one memory with
// one registered read port. Reset clears control state and the vertex count;
// the store itself is not cleared. in_req stalls while a request is worked
// on; a finished result waits in the done state while the output register
// is still full, which holds off the request after it.
`include "polyline_arc_coordinate_assert.svh"

module polyline_arc_coordinate import pac_pkg::*; #(
    parameter int MAX_VERTICES = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    pac_in_if.sink    in_req,
    pac_out_if.source out_rsp,
    pac_cfg_if.sink   cfg
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int ACC_W  = (LEN_W + ADDR_W + 1 > ARC_W) ? LEN_W + ADDR_W + 1 : ARC_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

    typedef enum logic [4:0] {
        S_IDLE, S_DONE, S_FIRST, S_VERT0, S_NEXT, S_VERT,
        S_LEN_A, S_LEN_B, S_LEN_C, S_SQRT, S_LEN_D,
        S_DOT_A, S_DOT_B, S_DOT_C, S_DIV, S_P_D,
        S_PX_A, S_PX_B, S_PX_C, S_PY_B, S_PY_C, S_CHECK,
        S_DIST_A, S_DIST_B, S_DIST_C, S_DIST_D, S_PASS_END
    } state_t;

    state_t state_reg, ret_reg;

    logic [SNAP_W-1:0]       snap_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic [CNT_W-1:0]        cnt_reg, i_reg;
    logic signed [CRD_W-1:0] px_reg, py_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [DIF_W-1:0] sx_reg, sy_reg;
    logic signed [E_W-1:0]   ex_reg, ey_reg;
    logic [LEN_W-1:0]        len_reg;
    logic                    deg_reg, pass_reg, found_reg;
    logic signed [P_W-1:0]   p_reg;
    logic signed [Q_W-1:0]   qx_reg;
    logic [ACC_W-1:0]        trav_reg, total_reg, best_arc_reg;
    logic [DIST_W-1:0]       best_reg;
    logic signed [PROD_W-1:0] prod_reg, acc_reg;
    logic [SQ_W-1:0]         sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [DIV_W-1:0]        dv_num_reg;
    logic [LEN_W-1:0]        dv_rem_reg;
    logic [DIVC_W-1:0]       dv_cnt_reg;
    logic                    dv_neg_reg;
    logic [STAT_W-1:0]       res_status_reg, out_status_reg;
    logic [ACC_W-1:0]        res_arc_reg;
    logic [ARC_W-1:0]        out_arc_reg;
    logic                    out_valid_reg;

    logic [2*CRD_W-1:0] vtx_mem [MAX_VERTICES];
    logic [2*CRD_W-1:0] rd_data_reg;

    // |dx| and |dy| both within tolerance
    function automatic logic near_fn(input logic signed [E_W-1:0] dx,
                                     input logic signed [E_W-1:0] dy,
                                     input logic [TOL_W-1:0] t);
        logic signed [E_W-1:0] ts;
        ts = $signed({{(E_W-TOL_W){1'b0}}, t});
        return (dx <= ts) && (dx >= -ts) && (dy <= ts) && (dy >= -ts);
    endfunction

    function automatic logic [ARC_W-1:0] sat_fn(input logic [ACC_W-1:0] v);
        return (|v[ACC_W-1:ARC_W]) ? {ARC_W{1'b1}} : v[ARC_W-1:0];
    endfunction

    // handshakes
    logic in_fire, out_fire, cfg_fire, out_load;
    assign in_req.ready  = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign in_fire       = in_req.valid && in_req.ready;
    assign out_fire      = out_rsp.valid && out_rsp.ready;
    assign cfg_fire      = cfg.valid && cfg.ready;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || out_rsp.ready);
    assign out_rsp.valid     = out_valid_reg;
    assign out_rsp.status    = out_status_reg;
    assign out_rsp.arc_coord = out_arc_reg;

    // vertex store ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic signed [CRD_W-1:0] rd_x, rd_y;
    assign wr_en = in_fire && ((in_req.operation == OP_START) ||
                   ((in_req.operation == OP_APPEND) && (cnt_reg < CNT_MAX)));
    assign wr_addr = (in_req.operation == OP_START) ? '0 : cnt_reg[ADDR_W-1:0];
    assign rd_addr = (state_reg == S_FIRST) ? '0 : i_reg[ADDR_W-1:0];
    assign rd_x = $signed(rd_data_reg[2*CRD_W-1:CRD_W]);
    assign rd_y = $signed(rd_data_reg[CRD_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vtx_mem[wr_addr] <= {in_req.x_coord, in_req.y_coord};
        end
        rd_data_reg <= vtx_mem[rd_addr];
    end

    // shared multiplier operand select
    logic signed [MUL_W-1:0] mul_a, mul_b;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_LEN_A:  begin mul_a = MUL_W'(sx_reg); mul_b = MUL_W'(sx_reg); end
            S_LEN_B:  begin mul_a = MUL_W'(sy_reg); mul_b = MUL_W'(sy_reg); end
            S_DOT_A:  begin mul_a = ex_reg;         mul_b = MUL_W'(sx_reg); end
            S_DOT_B:  begin mul_a = ey_reg;         mul_b = MUL_W'(sy_reg); end
            S_PX_A:   begin mul_a = MUL_W'(sx_reg); mul_b = MUL_W'(p_reg);  end
            S_PX_C:   begin mul_a = MUL_W'(sy_reg); mul_b = MUL_W'(p_reg);  end
            S_DIST_A: begin mul_a = ex_reg;         mul_b = ex_reg;         end
            S_DIST_B: begin mul_a = ey_reg;         mul_b = ey_reg;         end
            default:  begin mul_a = '0;             mul_b = '0;             end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // square root step
    logic signed [PROD_W-1:0] prod_sum;
    logic [SQ_W-1:0]          sq_sum;
    logic                     sq_ge;
    assign prod_sum = acc_reg + prod_reg;
    assign sq_sum   = sq_res_reg + sq_bit_reg;
    assign sq_ge    = (sq_v_reg >= sq_sum);

    // divider start and step
    logic signed [DIV_W-1:0] dv_n, dv_quo, len_s, tol_s;
    logic [DIV_W-1:0]        dv_mag, dv_start;
    logic [LEN_W:0]          dv_t, dv_sub;
    logic                    dv_ge;
    assign dv_n     = (state_reg == S_DOT_C) ? prod_sum : prod_reg;
    assign dv_mag   = dv_n[DIV_W-1] ? $unsigned(-dv_n) : $unsigned(dv_n);
    assign dv_start = dv_mag + DIV_W'(len_reg >> 1);
    assign dv_t     = {dv_rem_reg, dv_num_reg[DIV_W-1]};
    assign dv_ge    = (dv_t >= {1'b0, len_reg});
    assign dv_sub   = dv_t - {1'b0, len_reg};
    assign dv_quo   = dv_neg_reg ? -$signed(dv_num_reg) : $signed(dv_num_reg);
    assign len_s    = $signed(DIV_W'(len_reg));
    assign tol_s    = $signed(DIV_W'(tol_reg));

    // vertex and projection error checks
    logic [LEN_W-1:0]      sq_len;
    logic                  sq_deg, near_a, near_b, near_q;
    logic signed [E_W-1:0] dax, day, dbx, dby, qy_err;
    logic signed [Q_W-1:0] qy_val;
    logic [ACC_W-1:0]      p_cl, trav_add;
    logic [DIST_W-1:0]     cand_dist;
    assign sq_len   = sq_res_reg[LEN_W-1:0];
    assign sq_deg   = (sq_res_reg <= SQ_W'(tol_reg));
    assign dax      = E_W'(ax_reg) - E_W'(px_reg);
    assign day      = E_W'(ay_reg) - E_W'(py_reg);
    assign dbx      = E_W'(bx_reg) - E_W'(px_reg);
    assign dby      = E_W'(by_reg) - E_W'(py_reg);
    assign near_a   = near_fn(dax, day, tol_reg);
    assign near_b   = near_fn(dbx, dby, tol_reg);
    assign near_q   = near_fn(ex_reg, ey_reg, tol_reg);
    assign qy_val   = Q_W'(ay_reg) + dv_quo[Q_W-1:0];
    assign qy_err   = E_W'(qy_val) - E_W'(py_reg);
    assign p_cl     = p_reg[P_W-1] ? '0 :
                      (p_reg > $signed({1'b0, len_reg})) ? ACC_W'(len_reg) :
                      ACC_W'($unsigned(p_reg));
    assign trav_add = trav_reg + ACC_W'(len_reg);
    assign cand_dist = sq_res_reg[DIST_W-1:0];

    // sequencer, datapath and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            snap_reg       <= SNAP_RESET;
            tol_reg        <= TOL_RESET;
            cnt_reg        <= '0;
            i_reg          <= '0;
            px_reg         <= '0;
            py_reg         <= '0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            bx_reg         <= '0;
            by_reg         <= '0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            ex_reg         <= '0;
            ey_reg         <= '0;
            len_reg        <= '0;
            deg_reg        <= 1'b0;
            pass_reg       <= 1'b0;
            found_reg      <= 1'b0;
            p_reg          <= '0;
            qx_reg         <= '0;
            trav_reg       <= '0;
            total_reg      <= '0;
            best_arc_reg   <= '0;
            best_reg       <= '0;
            acc_reg        <= '0;
            sq_v_reg       <= '0;
            sq_res_reg     <= '0;
            sq_bit_reg     <= '0;
            dv_num_reg     <= '0;
            dv_rem_reg     <= '0;
            dv_cnt_reg     <= '0;
            dv_neg_reg     <= 1'b0;
            res_status_reg <= ST_STORED;
            res_arc_reg    <= '0;
            out_status_reg <= ST_STORED;
            out_arc_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_fire)
            begin
                case (cfg.index)
                    CFG_SNAP: snap_reg <= cfg.data[SNAP_W-1:0];
                    CFG_TOL:  tol_reg  <= cfg.data[TOL_W-1:0];
                    default:  ;
                endcase
            end

            // load a new result or drop a delivered one
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        res_arc_reg <= '0;
                        unique case (in_req.operation)
                            OP_START:
                            begin
                                cnt_reg        <= CNT_W'(1);
                                res_status_reg <= ST_STORED;
                                state_reg      <= S_DONE;
                            end
                            OP_APPEND:
                            begin
                                if (cnt_reg < CNT_MAX)
                                begin
                                    cnt_reg        <= cnt_reg + CNT_W'(1);
                                    res_status_reg <= ST_STORED;
                                end
                                else
                                begin
                                    res_status_reg <= ST_FULL;
                                end
                                state_reg <= S_DONE;
                            end
                            OP_QUERY:
                            begin
                                px_reg    <= in_req.x_coord;
                                py_reg    <= in_req.y_coord;
                                pass_reg  <= 1'b0;
                                trav_reg  <= '0;
                                total_reg <= '0;
                                i_reg     <= CNT_W'(1);
                                if (cnt_reg == '0)
                                begin
                                    res_status_reg <= ST_EMPTY;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_FIRST;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // hold the result until the output slot is free
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_status_reg <= res_status_reg;
                        out_arc_reg    <= sat_fn(res_arc_reg);
                        state_reg      <= S_IDLE;
                    end
                end

                S_FIRST: state_reg <= S_VERT0;

                S_VERT0:
                begin
                    bx_reg    <= rd_x;
                    by_reg    <= rd_y;
                    state_reg <= S_NEXT;
                end

                S_NEXT:
                begin
                    if (i_reg < cnt_reg)
                    begin
                        state_reg <= S_VERT;
                    end
                    else
                    begin
                        state_reg <= S_PASS_END;
                    end
                end

                // advance to the next segment
                S_VERT:
                begin
                    ax_reg    <= bx_reg;
                    ay_reg    <= by_reg;
                    bx_reg    <= rd_x;
                    by_reg    <= rd_y;
                    sx_reg    <= DIF_W'(rd_x) - DIF_W'(bx_reg);
                    sy_reg    <= DIF_W'(rd_y) - DIF_W'(by_reg);
                    i_reg     <= i_reg + CNT_W'(1);
                    state_reg <= S_LEN_A;
                end

                S_LEN_A: state_reg <= S_LEN_B;

                S_LEN_B:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_LEN_C;
                end

                S_LEN_C:
                begin
                    sq_v_reg   <= $unsigned(prod_sum);
                    sq_res_reg <= '0;
                    sq_bit_reg <= SQ_W'(1) << (SQ_W - 2);
                    ret_reg    <= S_LEN_D;
                    state_reg  <= S_SQRT;
                end

                // one result bit per cycle
                S_SQRT:
                begin
                    if (sq_ge)
                    begin
                        sq_v_reg   <= sq_v_reg - sq_sum;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0])
                    begin
                        state_reg <= ret_reg;
                    end
                end

                S_LEN_D:
                begin
                    len_reg <= sq_len;
                    deg_reg <= sq_deg;
                    ex_reg  <= -dax;
                    ey_reg  <= -day;
                    if (!pass_reg)
                    begin
                        total_reg <= total_reg + ACC_W'(sq_len);
                    end
                    if (!sq_deg)
                    begin
                        state_reg <= S_DOT_A;
                    end
                    else if (pass_reg)
                    begin
                        state_reg <= S_DIST_A;
                    end
                    else if (near_a || near_b)
                    begin
                        res_status_reg <= ST_FOUND;
                        res_arc_reg    <= trav_reg;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end

                S_DOT_A: state_reg <= S_DOT_B;

                S_DOT_B:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_DOT_C;
                end

                S_DOT_C, S_PX_B, S_PY_B:
                begin
                    dv_neg_reg <= dv_n[DIV_W-1];
                    dv_num_reg <= dv_start;
                    dv_rem_reg <= '0;
                    dv_cnt_reg <= DIVC_W'(DIV_W - 1);
                    state_reg  <= S_DIV;
                    unique case (state_reg)
                        S_DOT_C: ret_reg <= S_P_D;
                        S_PX_B:  ret_reg <= S_PX_C;
                        default: ret_reg <= S_PY_C;
                    endcase
                end

                // one quotient bit per cycle
                S_DIV:
                begin
                    dv_rem_reg <= dv_ge ? dv_sub[LEN_W-1:0] : dv_t[LEN_W-1:0];
                    dv_num_reg <= {dv_num_reg[DIV_W-2:0], dv_ge};
                    dv_cnt_reg <= dv_cnt_reg - DIVC_W'(1);
                    if (dv_cnt_reg == '0)
                    begin
                        state_reg <= ret_reg;
                    end
                end

                S_P_D:
                begin
                    if (pass_reg)
                    begin
                        if (dv_quo < 0)
                        begin
                            p_reg <= '0;
                        end
                        else if (dv_quo > len_s)
                        begin
                            p_reg <= P_W'(len_reg);
                        end
                        else
                        begin
                            p_reg <= dv_quo[P_W-1:0];
                        end
                        state_reg <= S_PX_A;
                    end
                    else if ((dv_quo < -tol_s) || (dv_quo > len_s + tol_s))
                    begin
                        trav_reg  <= trav_add;
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        p_reg     <= dv_quo[P_W-1:0];
                        state_reg <= S_PX_A;
                    end
                end

                S_PX_A: state_reg <= S_PX_B;

                S_PX_C:
                begin
                    qx_reg    <= Q_W'(ax_reg) + dv_quo[Q_W-1:0];
                    state_reg <= S_PY_B;
                end

                S_PY_C:
                begin
                    ex_reg    <= E_W'(qx_reg) - E_W'(px_reg);
                    ey_reg    <= qy_err;
                    state_reg <= pass_reg ? S_DIST_A : S_CHECK;
                end

                S_CHECK:
                begin
                    if (near_q)
                    begin
                        res_status_reg <= ST_FOUND;
                        res_arc_reg    <= trav_reg + p_cl;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        trav_reg  <= trav_add;
                        state_reg <= S_NEXT;
                    end
                end

                S_DIST_A: state_reg <= S_DIST_B;

                S_DIST_B:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_DIST_C;
                end

                S_DIST_C:
                begin
                    sq_v_reg   <= $unsigned(prod_sum);
                    sq_res_reg <= '0;
                    sq_bit_reg <= SQ_W'(1) << (SQ_W - 2);
                    ret_reg    <= S_DIST_D;
                    state_reg  <= S_SQRT;
                end

                // later ties win
                S_DIST_D:
                begin
                    if (cand_dist <= best_reg)
                    begin
                        best_reg     <= cand_dist;
                        best_arc_reg <= deg_reg ? trav_reg : trav_reg + p_cl;
                        found_reg    <= 1'b1;
                    end
                    if (!deg_reg)
                    begin
                        trav_reg <= trav_add;
                    end
                    state_reg <= S_NEXT;
                end

                S_PASS_END:
                begin
                    if (!pass_reg)
                    begin
                        if (near_b)
                        begin
                            res_status_reg <= ST_FOUND;
                            res_arc_reg    <= total_reg;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            pass_reg  <= 1'b1;
                            trav_reg  <= '0;
                            best_reg  <= DIST_W'(snap_reg);
                            found_reg <= 1'b0;
                            i_reg     <= CNT_W'(1);
                            state_reg <= S_FIRST;
                        end
                    end
                    else
                    begin
                        res_status_reg <= found_reg ? ST_FOUND : ST_NOT_ON_PATH;
                        res_arc_reg    <= found_reg ? best_arc_reg : '0;
                        state_reg      <= S_DONE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `PAC_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_MAX)
    `PAC_ASSERT_IMPL(a_arc_zero, out_valid_reg && (out_status_reg != ST_FOUND), out_arc_reg == '0)
    `PAC_ASSERT_IMPL(a_walk_bound, (state_reg != S_IDLE) && (state_reg != S_DONE), i_reg <= cnt_reg)

endmodule
